### sv/pwhd_pkg.sv
// Package for the pilot-wire heater order driver: types, codes and constants.
// Used by every module and interface of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package pwhd_pkg;

    // Widths of the timer, the configuration registers and the level.
    localparam int TIMER_BITS = 19;
    localparam int CFG_BITS   = 19;
    localparam int LEVEL_BITS = 7;
    localparam int VALUE_BITS = 16;

    typedef logic [TIMER_BITS-1:0] t_count;
    typedef logic [CFG_BITS-1:0]   t_cfg_data;
    typedef logic [LEVEL_BITS-1:0] t_level;

    // Item kinds on the input channel. The fourth code carries no meaning.
    typedef enum logic [1:0] {
        MODE_TICK   = 2'd0,
        MODE_DIMMER = 2'd1,
        MODE_SWITCH = 2'd2
    } t_mode;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_IDLE_C2  = 2'd0,
        CFG_PULSE_C2 = 2'd1,
        CFG_IDLE_C1  = 2'd2,
        CFG_PULSE_C1 = 2'd3
    } t_cfg_idx;

    // Heater orders.
    typedef enum logic [2:0] {
        ORD_OFF     = 3'd0,
        ORD_FROST   = 3'd1,
        ORD_ECO     = 3'd2,
        ORD_C2      = 3'd3,
        ORD_C1      = 3'd4,
        ORD_COMFORT = 3'd5
    } t_order;

    // Drive pair codes: bit 1 negative, bit 0 positive.
    localparam logic [1:0] DRIVE_NONE     = 2'b00;
    localparam logic [1:0] DRIVE_POS_ONLY = 2'b01;
    localparam logic [1:0] DRIVE_NEG_ONLY = 2'b10;
    localparam logic [1:0] DRIVE_BOTH     = 2'b11;

    // Level limits and band edges.
    localparam t_level LEVEL_MAX     = 7'd100;
    localparam t_level BAND_OFF_MAX  = 7'd10;
    localparam t_level BAND_FROST_MAX = 7'd20;
    localparam t_level BAND_ECO_MAX  = 7'd30;
    localparam t_level BAND_C2_MAX   = 7'd40;
    localparam t_level BAND_C1_MAX   = 7'd50;

    // Register values after reset.
    localparam t_cfg_data RST_IDLE_C2  = 19'd293000;
    localparam t_cfg_data RST_PULSE_C2 = 19'd7000;
    localparam t_cfg_data RST_IDLE_C1  = 19'd297000;
    localparam t_cfg_data RST_PULSE_C1 = 19'd3000;

    // Decoded input item.
    typedef struct packed {
        logic   tick;
        logic   set_level;
        t_level level;
    } t_cmd;

    // One result item.
    typedef struct packed {
        logic   positive_drive;
        logic   negative_drive;
        t_order order_code;
        t_level stored_level;
    } t_result;

    // Map a clamped level to its order band.
    function automatic t_order band_order(input t_level level);
        t_order ord;
        if (level <= BAND_OFF_MAX) begin
            ord = ORD_OFF;
        end else if (level <= BAND_FROST_MAX) begin
            ord = ORD_FROST;
        end else if (level <= BAND_ECO_MAX) begin
            ord = ORD_ECO;
        end else if (level <= BAND_C2_MAX) begin
            ord = ORD_C2;
        end else if (level <= BAND_C1_MAX) begin
            ord = ORD_C1;
        end else begin
            ord = ORD_COMFORT;
        end
        return ord;
    endfunction

    // Steady drive of each order; the cycling orders start idle.
    function automatic logic [1:0] order_drive(input t_order ord);
        logic [1:0] drv;
        unique case (ord)
            ORD_OFF:   drv = DRIVE_POS_ONLY;
            ORD_FROST: drv = DRIVE_NEG_ONLY;
            ORD_ECO:   drv = DRIVE_BOTH;
            default:   drv = DRIVE_NONE;
        endcase
        return drv;
    endfunction

endpackage

`default_nettype wire

### sv/pwhd_ifs.sv
// Valid/ready channel interfaces of the pilot-wire order driver.
// Depends on pwhd_pkg for the field types.
`timescale 1ns / 1ps
`default_nettype none

// Input items: ticks and level commands.
interface pwhd_in_if;
    logic                                 valid;
    logic                                 ready;
    logic [1:0]                           mode;
    logic signed [pwhd_pkg::VALUE_BITS-1:0] level_value;

    modport source (output valid, output mode, output level_value, input ready);
    modport sink   (input valid, input mode, input level_value, output ready);
endinterface

// Result items: drive state, order and stored level.
interface pwhd_out_if;
    logic                  valid;
    logic                  ready;
    logic                  positive_drive;
    logic                  negative_drive;
    logic [2:0]            order_code;
    pwhd_pkg::t_level      stored_level;

    modport source (output valid, output positive_drive, output negative_drive,
                    output order_code, output stored_level, input ready);
    modport sink   (input valid, input positive_drive, input negative_drive,
                    input order_code, input stored_level, output ready);
endinterface

// Configuration register writes.
interface pwhd_cfg_if;
    logic                  valid;
    logic                  ready;
    logic [1:0]            index;
    pwhd_pkg::t_cfg_data   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### sv/pwhd_cmd_decode.sv
// Decodes one input item into a tick flag or a clamped level command.
// Depends on pwhd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pwhd_cmd_decode (
    input  wire logic [1:0]                           i_mode,
    input  wire logic signed [pwhd_pkg::VALUE_BITS-1:0] i_level_value,
    output pwhd_pkg::t_cmd                            o_cmd
);
    import pwhd_pkg::*;

    logic   neg_value;
    logic   zero_value;
    logic   over_max;
    t_level dimmer_level;
    t_level switch_level;

    // Dimmer values clamp to 0..100; a switch value times 100 is 0 or 100.
    assign neg_value    = i_level_value[VALUE_BITS-1];
    assign zero_value   = (i_level_value == '0);
    assign over_max     = (i_level_value > $signed(VALUE_BITS'(LEVEL_MAX)));
    assign dimmer_level = neg_value ? '0 : (over_max ? LEVEL_MAX : i_level_value[LEVEL_BITS-1:0]);
    assign switch_level = (neg_value || zero_value) ? '0 : LEVEL_MAX;

    // Classify the item.
    always_comb begin
        o_cmd = '0;
        unique case (i_mode)
            MODE_TICK: begin
                o_cmd.tick = 1'b1;
            end
            MODE_DIMMER: begin
                o_cmd.set_level = 1'b1;
                o_cmd.level     = dimmer_level;
            end
            MODE_SWITCH: begin
                o_cmd.set_level = 1'b1;
                o_cmd.level     = switch_level;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

### sv/pwhd_order_core.sv
// Order state, comfort cycle countdown and configuration registers.
// Presents the state after the current item. Depends on pwhd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pwhd_order_core (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [1:0]           i_cfg_idx,
    input  wire pwhd_pkg::t_cfg_data  i_cfg_data,
    input  wire logic                 i_accept,
    input  wire pwhd_pkg::t_cmd       i_cmd,
    output pwhd_pkg::t_result         o_next
);
    import pwhd_pkg::*;

    t_cfg_data  r_idle_c2, r_pulse_c2, r_idle_c1, r_pulse_c1;
    t_level     r_level, n_level;
    t_order     r_order, n_order;
    logic       r_idle, n_idle;
    t_count     r_cnt, n_cnt;
    logic [1:0] r_drive, n_drive;

    t_order     new_order;
    logic       new_cycling;
    logic       cur_cycling;
    t_count     new_idle_len;
    t_count     cur_idle_len;
    t_count     cur_pulse_len;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_c2  <= RST_IDLE_C2;
            r_pulse_c2 <= RST_PULSE_C2;
            r_idle_c1  <= RST_IDLE_C1;
            r_pulse_c1 <= RST_PULSE_C1;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_IDLE_C2:  r_idle_c2  <= i_cfg_data;
                CFG_PULSE_C2: r_pulse_c2 <= i_cfg_data;
                CFG_IDLE_C1:  r_idle_c1  <= i_cfg_data;
                CFG_PULSE_C1: r_pulse_c1 <= i_cfg_data;
                default:      r_idle_c2  <= r_idle_c2;
            endcase
        end
    end

    // Period lengths for the new band and for the running order.
    assign new_order     = band_order(i_cmd.level);
    assign new_cycling   = (new_order == ORD_C2) || (new_order == ORD_C1);
    assign cur_cycling   = (r_order == ORD_C2) || (r_order == ORD_C1);
    assign new_idle_len  = t_count'((new_order == ORD_C2) ? r_idle_c2 : r_idle_c1);
    assign cur_idle_len  = t_count'((r_order == ORD_C2) ? r_idle_c2 : r_idle_c1);
    assign cur_pulse_len = t_count'((r_order == ORD_C2) ? r_pulse_c2 : r_pulse_c1);

    // Next state: a changed level reapplies its order, a tick steps the cycle.
    always_comb begin
        n_level = r_level;
        n_order = r_order;
        n_idle  = r_idle;
        n_cnt   = r_cnt;
        n_drive = r_drive;
        if (i_accept) begin
            if (i_cmd.set_level && (i_cmd.level != r_level)) begin
                n_level = i_cmd.level;
                n_order = new_order;
                n_drive = order_drive(new_order);
                n_idle  = new_cycling;
                n_cnt   = new_cycling ? new_idle_len : '0;
            end else if (i_cmd.tick && cur_cycling) begin
                if (r_cnt > t_count'(1)) begin
                    n_cnt = r_cnt - t_count'(1);
                end else if (r_idle) begin
                    n_idle  = 1'b0;
                    n_drive = DRIVE_BOTH;
                    n_cnt   = cur_pulse_len;
                end else begin
                    n_idle  = 1'b1;
                    n_drive = DRIVE_NONE;
                    n_cnt   = cur_idle_len;
                end
            end
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0;
            r_order <= ORD_OFF;
            r_idle  <= 1'b0;
            r_cnt   <= '0;
            r_drive <= DRIVE_POS_ONLY;
        end else begin
            r_level <= n_level;
            r_order <= n_order;
            r_idle  <= n_idle;
            r_cnt   <= n_cnt;
            r_drive <= n_drive;
        end
    end

    assign o_next.positive_drive = n_drive[0];
    assign o_next.negative_drive = n_drive[1];
    assign o_next.order_code     = n_order;
    assign o_next.stored_level   = n_level;

`ifndef SYNTHESIS
    // Outside the cycling orders the countdown and the phase stay cleared.
    a_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !cur_cycling |-> (r_cnt == '0) && !r_idle)
        else $error("countdown active outside comfort cycle");

    // The drive pair always agrees with a steady order.
    a_steady_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !cur_cycling |-> (r_drive == order_drive(r_order)))
        else $error("drive pair does not match order");

    // Within the idle phase nothing is driven.
    a_idle_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cur_cycling && r_idle) |-> (r_drive == DRIVE_NONE))
        else $error("drive during idle phase");

    // A tick above one counts the countdown down by one.
    a_count_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_cmd.tick && cur_cycling && (r_cnt > t_count'(1)))
        |=> (r_cnt == $past(r_cnt) - t_count'(1)) && $stable(r_drive))
        else $error("countdown did not step");

    // The stored level never exceeds the maximum.
    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept |=> (r_level <= LEVEL_MAX))
        else $error("stored level out of range");
`endif

endmodule

`default_nettype wire

### sv/pilot_wire_heater_order_driver_top.sv
// Top level of the pilot-wire heater order driver.
// Depends on pwhd_pkg, the channel interfaces, pwhd_cmd_decode and pwhd_order_core.
//
// Use: items enter on i_in (mode 0 a one-millisecond tick, 1 a dimmer level,
// 2 an on/off switch value, 3 ignored). Each transfer on i_in gives exactly
// one result on o_out: the two half-wave drive enables, the current order and
// the stored level after that item. i_cfg writes the four comfort-cycle
// period registers; it is always ready and is meant for use while idle.
// The result is registered and appears on o_out in the cycle after its input transfer.
// Throughput: one item per cycle unless o_out stalls. The state update is a single
// compare and count step between the input handshake and the result register.
// Stall: i_in.ready is high while the result register is empty or being
// drained in the same cycle; when o_out stalls the result holds and i_in
// takes nothing more until it is taken.
// Reset (i_rst_n low, synchronous): level 0, order off, positive drive on,
// countdown cleared, period registers back to their defaults, o_out empty.
`timescale 1ns / 1ps
`default_nettype none

module pilot_wire_heater_order_driver_top (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    pwhd_in_if.sink    i_in,
    pwhd_out_if.source o_out,
    pwhd_cfg_if.sink   i_cfg
);
    import pwhd_pkg::*;

    t_cmd    cmd;
    t_result next_res;
    t_result r_res;
    logic    r_out_valid;
    logic    in_ready;
    logic    accept;

    // Input transfer whenever the result register can take a new value.
    assign in_ready    = !r_out_valid || o_out.ready;
    assign accept      = i_in.valid && in_ready;
    assign i_in.ready  = in_ready;
    assign i_cfg.ready = 1'b1;

    pwhd_cmd_decode u_decode (
        .i_mode        (i_in.mode),
        .i_level_value (i_in.level_value),
        .o_cmd         (cmd)
    );

    pwhd_order_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg.valid),
        .i_cfg_idx  (i_cfg.index),
        .i_cfg_data (i_cfg.data),
        .i_accept   (accept),
        .i_cmd      (cmd),
        .o_next     (next_res)
    );

    // Result register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_ready) begin
            r_out_valid <= i_in.valid;
        end
    end

    // Result register payload.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res <= next_res;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.positive_drive = r_res.positive_drive;
    assign o_out.negative_drive = r_res.negative_drive;
    assign o_out.order_code     = r_res.order_code;
    assign o_out.stored_level   = r_res.stored_level;

endmodule

`default_nettype wire

### tb/tb.sv
// Self-checking testbench for the pilot-wire heater order driver top level.
// Depends on pwhd_pkg, the channel interfaces in pwhd_ifs.sv and the driver RTL.
// Tracks level, order, comfort cycle phase and countdown to predict every result.
`timescale 1ns / 1ps

module tb;
    import pwhd_pkg::*;

    localparam int         CYCLE_LIMIT = 1000000;
    localparam int         MAX_REPORTS = 10;
    localparam int         IDLE_SLACK  = 3;
    localparam int         HOLD_CYCLES = 250;
    localparam t_cfg_data  PERIOD_MAX  = 19'h7FFFF;
    // The fourth mode code is not decoded by the block.
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    logic clk = 1'b0;
    logic rst_n;

    pwhd_in_if  item_ch ();
    pwhd_out_if status_ch ();
    pwhd_cfg_if cfg_ch ();

    pilot_wire_heater_order_driver_top u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (item_ch),
        .o_out   (status_ch),
        .i_cfg   (cfg_ch)
    );

    always #2 clk = ~clk;

    // Shadow of the heater state and of the four period registers.
    t_level    level_now = '0;
    t_order    order_now = ORD_OFF;
    logic      idle_now  = 1'b0;
    t_count    count_now = '0;
    logic [1:0] drive_now = DRIVE_POS_ONLY;
    t_cfg_data period_regs [4] = '{RST_IDLE_C2, RST_PULSE_C2, RST_IDLE_C1, RST_PULSE_C1};

    t_result heater_status_q [$];
    int      fail_count    = 0;
    int      cycle_count   = 0;
    int      gap_free_left = 0;
    logic    hold_request  = 1'b0;

    // Period of the running comfort order, idle phase or pulse phase.
    function automatic t_count comfort_period(input logic want_pulse);
        if (order_now == ORD_C2) begin
            return want_pulse ? period_regs[CFG_PULSE_C2] : period_regs[CFG_IDLE_C2];
        end
        return want_pulse ? period_regs[CFG_PULSE_C1] : period_regs[CFG_IDLE_C1];
    endfunction

    // A new stored level selects its order; cycling orders restart idle.
    function automatic void enter_band();
        idle_now  = 1'b0;
        count_now = '0;
        if (level_now <= BAND_OFF_MAX) begin
            order_now = ORD_OFF;
            drive_now = DRIVE_POS_ONLY;
        end else if (level_now <= BAND_FROST_MAX) begin
            order_now = ORD_FROST;
            drive_now = DRIVE_NEG_ONLY;
        end else if (level_now <= BAND_ECO_MAX) begin
            order_now = ORD_ECO;
            drive_now = DRIVE_BOTH;
        end else if (level_now <= BAND_C1_MAX) begin
            order_now = (level_now <= BAND_C2_MAX) ? ORD_C2 : ORD_C1;
            drive_now = DRIVE_NONE;
            idle_now  = 1'b1;
            count_now = comfort_period(1'b0);
        end else begin
            order_now = ORD_COMFORT;
            drive_now = DRIVE_NONE;
        end
    endfunction

    // Applies one item to the shadow state and returns the status it leaves.
    function automatic t_result step_heater(input logic [1:0] mode,
                                            input logic signed [15:0] value);
        int      req;
        t_result res;
        case (mode)
            MODE_TICK: begin
                if (order_now == ORD_C2 || order_now == ORD_C1) begin
                    // A count of zero or one ends the phase on this tick.
                    if (count_now > 1) begin
                        count_now = count_now - 1'b1;
                    end else if (idle_now) begin
                        idle_now  = 1'b0;
                        drive_now = DRIVE_BOTH;
                        count_now = comfort_period(1'b1);
                    end else begin
                        idle_now  = 1'b1;
                        drive_now = DRIVE_NONE;
                        count_now = comfort_period(1'b0);
                    end
                end
            end
            MODE_DIMMER, MODE_SWITCH: begin
                req = int'(value);
                if (mode == MODE_SWITCH) begin
                    req = req * 100;
                end
                if (req > int'(LEVEL_MAX)) begin
                    req = int'(LEVEL_MAX);
                end
                if (req < 0) begin
                    req = 0;
                end
                // Repeating the stored level leaves a running cycle alone.
                if (t_level'(req) != level_now) begin
                    level_now = t_level'(req);
                    enter_band();
                end
            end
            default: ;
        endcase
        res.positive_drive = drive_now[0];
        res.negative_drive = drive_now[1];
        res.order_code     = order_now;
        res.stored_level   = level_now;
        return res;
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
            $display("%s", msg);
        end
    endtask

    // Watch all three channels at the rising edge; results first, since a
    // result always belongs to an earlier input transfer.
    always @(posedge clk) begin
        t_result got;
        t_result want;
        if (rst_n) begin
            if (status_ch.valid && status_ch.ready) begin
                got = {status_ch.positive_drive, status_ch.negative_drive,
                       status_ch.order_code, status_ch.stored_level};
                if (heater_status_q.size() == 0) begin
                    note_failure($sformatf("unexpected result transfer: pos=%0b neg=%0b order=%0d level=%0d",
                                           got.positive_drive, got.negative_drive,
                                           got.order_code, got.stored_level));
                end else begin
                    want = heater_status_q.pop_front();
                    if (got.positive_drive !== want.positive_drive ||
                        got.negative_drive !== want.negative_drive ||
                        got.order_code !== want.order_code ||
                        got.stored_level !== want.stored_level) begin
                        note_failure($sformatf({"result mismatch: expected pos=%0b neg=%0b ",
                                                "order=%0d level=%0d, got pos=%0b neg=%0b ",
                                                "order=%0d level=%0d"},
                                               want.positive_drive, want.negative_drive,
                                               want.order_code, want.stored_level,
                                               got.positive_drive, got.negative_drive,
                                               got.order_code, got.stored_level));
                    end
                end
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                period_regs[cfg_ch.index] = cfg_ch.data;
            end
            if (item_ch.valid && item_ch.ready) begin
                heater_status_q.push_back(step_heater(item_ch.mode, item_ch.level_value));
            end
        end
    end

    // Run limit.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Result receiver: random stalls, clean stretches, and on request one
    // long hold-off so that the block backs up into its input.
    initial begin
        int   run_left;
        int   hold_left;
        int   pick;
        logic ready_next;
        run_left   = 0;
        hold_left  = 0;
        ready_next = 1'b1;
        status_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                status_ch.ready <= 1'b0;
            end else begin
                if (run_left == 0) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 15) begin
                        ready_next = 1'b1;
                        run_left   = $urandom_range(30, 100);
                    end else if (pick < 65) begin
                        ready_next = 1'b1;
                        run_left   = $urandom_range(1, 6);
                    end else if (pick < 92) begin
                        ready_next = 1'b0;
                        run_left   = $urandom_range(1, 3);
                    end else begin
                        ready_next = 1'b0;
                        run_left   = $urandom_range(10, 40);
                    end
                end
                run_left--;
                status_ch.ready <= ready_next;
            end
        end
    end

    // Idle cycles before the next input transfer: mostly none or a few,
    // now and then a long gap or a run of back-to-back items.
    function automatic int pick_gap();
        int pick;
        if (gap_free_left > 0) begin
            gap_free_left--;
            return 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
            gap_free_left = $urandom_range(30, 80);
            return 0;
        end
        if (pick < 55) return 0;
        if (pick < 85) return $urandom_range(1, 3);
        if (pick < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 50);
    endfunction

    // Offers one item after the given gap and returns once it is transferred.
    // Valid stays high so that the next item can follow without a bubble.
    task automatic send_item(input logic [1:0] mode, input logic signed [15:0] value,
                             input int gap);
        if (gap > 0) begin
            @(negedge clk);
            item_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        item_ch.valid       <= 1'b1;
        item_ch.mode        <= mode;
        item_ch.level_value <= value;
        @(posedge clk);
        while (!item_ch.ready) @(posedge clk);
    endtask

    // Stops offering items and waits for every outstanding result.
    task automatic wait_idle();
        @(negedge clk);
        item_ch.valid <= 1'b0;
        while (heater_status_q.size() != 0) @(posedge clk);
        repeat (IDLE_SLACK) @(posedge clk);
    endtask

    task automatic write_period(input t_cfg_idx idx, input t_cfg_data value);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic configure_periods(input t_cfg_data idle_c2, input t_cfg_data pulse_c2,
                                     input t_cfg_data idle_c1, input t_cfg_data pulse_c1);
        wait_idle();
        write_period(CFG_IDLE_C2, idle_c2);
        write_period(CFG_PULSE_C2, pulse_c2);
        write_period(CFG_IDLE_C1, idle_c1);
        write_period(CFG_PULSE_C1, pulse_c1);
    endtask

    // Unused mode, a tick in the off order and a repeat of the reset level.
    task automatic test_after_reset();
        send_item(MODE_UNUSED, 16'sh7FFF, pick_gap());
        send_item(MODE_TICK, 16'shFFFF, pick_gap());
        send_item(MODE_DIMMER, 16'sd0, pick_gap());
    endtask

    // Band edges, clamping at both ends and wide switch values.
    task automatic test_level_bands();
        logic signed [15:0] levels [] = '{16'sh7FFF, 16'sd10, 16'sd11, 16'sd21,
                                          16'sd31, 16'sd41, 16'sd51, 16'sh8000};
        foreach (levels[i]) begin
            send_item(MODE_DIMMER, levels[i], pick_gap());
        end
        send_item(MODE_SWITCH, 16'sh7FFF, pick_gap());
        send_item(MODE_SWITCH, 16'sh8000, pick_gap());
    endtask

    // Both comfort cycles with short periods: phase flips, a repeated level
    // that must not restart, and a level change inside the band that must.
    task automatic test_comfort_cycles();
        configure_periods(19'd2, 19'd1, 19'd3, 19'd2);
        send_item(MODE_DIMMER, 16'sd35, pick_gap());
        repeat (3) send_item(MODE_TICK, 16'($urandom), pick_gap());
        send_item(MODE_DIMMER, 16'sd35, pick_gap());
        send_item(MODE_TICK, 16'($urandom), pick_gap());
        send_item(MODE_DIMMER, 16'sd36, pick_gap());
        send_item(MODE_DIMMER, 16'sd45, pick_gap());
        repeat (3) send_item(MODE_TICK, 16'($urandom), pick_gap());
    endtask

    // Period registers of zero behave as one tick.
    task automatic test_zero_periods();
        configure_periods('0, '0, '0, '0);
        send_item(MODE_DIMMER, 16'sd33, pick_gap());
        repeat (2) send_item(MODE_TICK, 16'($urandom), pick_gap());
        send_item(MODE_DIMMER, 16'sd47, pick_gap());
        send_item(MODE_TICK, 16'($urandom), pick_gap());
    endtask

    // Random traffic over several period settings, weighted toward the
    // cycling bands and ticks so that the countdown wraps many times.
    task automatic test_random_traffic();
        int                 pick;
        int                 count;
        logic [1:0]         mode;
        logic signed [15:0] value;
        t_cfg_data          p [4];
        for (int phase = 0; phase < 6; phase++) begin
            for (int r = 0; r < 4; r++) begin
                case (phase)
                    0:       p[r] = 19'd1;
                    1:       p[r] = PERIOD_MAX;
                    2:       p[r] = t_cfg_data'($urandom_range(1, 6));
                    3:       p[r] = t_cfg_data'($urandom_range(1, 40));
                    4:       p[r] = ($urandom_range(0, 3) == 0) ? '0
                                    : t_cfg_data'($urandom_range(1, 5));
                    default: p[r] = (r % 2 == 0) ? t_cfg_data'($urandom_range(1, 500))
                                                 : t_cfg_data'($urandom_range(1, 10));
                endcase
            end
            count = (phase == 1) ? 150 : (phase == 2 || phase == 3) ? 335 : 310;
            configure_periods(p[0], p[1], p[2], p[3]);
            repeat (count) begin
                pick  = $urandom_range(0, 99);
                mode  = MODE_DIMMER;
                value = 16'($urandom);
                if (pick < 55) begin
                    mode = MODE_TICK;
                end else if (pick < 70) begin
                    value = 16'($urandom_range(31, 50));
                end else if (pick < 78) begin
                    value = 16'($urandom_range(0, 115) - 5);
                end else if (pick < 84) begin
                    value = 16'(level_now);
                end else if (pick < 89) begin
                    mode  = MODE_SWITCH;
                    value = 16'($urandom_range(0, 4) - 2);
                end else if (pick < 95) begin
                    mode = ($urandom_range(0, 1) == 0) ? MODE_DIMMER : MODE_SWITCH;
                end else begin
                    mode = MODE_UNUSED;
                end
                send_item(mode, value, pick_gap());
            end
        end
    endtask

    // The receiver holds off while items keep coming back to back.
    task automatic test_output_backpressure();
        configure_periods(19'd3, 19'd2, 19'd2, 19'd1);
        send_item(MODE_DIMMER, 16'sd38, 0);
        hold_request = 1'b1;
        repeat (80) send_item(MODE_TICK, 16'($urandom), 0);
        send_item(MODE_DIMMER, 16'sd44, 0);
        repeat (40) send_item(MODE_TICK, 16'($urandom), 0);
    endtask

    initial begin
        item_ch.valid       = 1'b0;
        item_ch.mode        = MODE_TICK;
        item_ch.level_value = '0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = CFG_IDLE_C2;
        cfg_ch.data         = '0;
        rst_n               = 1'b0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        test_after_reset();
        test_level_bands();
        test_comfort_cycles();
        test_zero_periods();
        test_random_traffic();
        test_output_backpressure();
        wait_idle();

        if (heater_status_q.size() != 0) begin
            note_failure($sformatf("%0d results never arrived", heater_status_q.size()));
        end
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

### files.f
sv/pwhd_pkg.sv
sv/pwhd_ifs.sv
sv/pwhd_cmd_decode.sv
sv/pwhd_order_core.sv
sv/pilot_wire_heater_order_driver_top.sv
tb/tb.sv
